// ===== hdl/jhbd_pkg.sv =====
package jhbd_pkg;

	localparam int DC_DEPTH = 16;
	localparam int AC_DEPTH = 256;
	localparam int MAX_LEN  = 16;
	localparam int DC_AW    = $clog2(DC_DEPTH);
	localparam int AC_AW    = $clog2(AC_DEPTH);
	localparam int CNT_W    = 9;

	localparam logic [1:0] KIND_COEF = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic REG_DC_COUNT = 1'b0;
	localparam logic REG_AC_COUNT = 1'b1;

	localparam logic OP_BIT  = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic SEL_DC = 1'b0;
	localparam logic SEL_AC = 1'b1;

	typedef enum logic [1:0] {
		PH_DC_CODE  = 2'd0,
		PH_DC_EXTRA = 2'd1,
		PH_AC_CODE  = 2'd2,
		PH_AC_EXTRA = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_COMMIT = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic [4:0]  len;
		logic [15:0] code;
		logic [7:0]  sym;
	} entry_t;

	typedef struct packed {
		logic load;
		logic take;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic res_v;
	} dp_status_t;

endpackage

// ===== hdl/jhbd_datapath.sv =====
module jhbd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jhbd_pkg::dp_cmd_t    cmd,
	output jhbd_pkg::dp_status_t status,
	input  logic                 stream_bit,
	input  logic                 table_select,
	input  logic [7:0]           entry_index,
	input  logic [4:0]           entry_code_length,
	input  logic [15:0]          entry_code,
	input  logic [7:0]           entry_symbol,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [8:0]           cfg_data,
	output logic [1:0]           result_kind,
	output logic [5:0]           position,
	output logic signed [15:0]   coefficient,
	output logic                 last_of_block
);
	import jhbd_pkg::*;

	entry_t dc_mem [DC_DEPTH];
	entry_t ac_mem [AC_DEPTH];
	entry_t dc_rd_s1, ac_rd_s1, ent;

	logic [4:0]        dc_count_q;
	logic [8:0]        ac_count_q;
	phase_t            phase_q, n_phase;
	logic [6:0]        bpos_q, n_bpos;
	logic [15:0]       acc_q, n_acc;
	logic [4:0]        bits_q, n_bits;
	logic [15:0]       va_q, n_va;
	logic [3:0]        elen_q, n_elen;
	logic [3:0]        ebs_q, n_ebs;
	logic              neg_q, n_neg;
	logic              bit_q, hit_q;
	logic [7:0]        sym_q;
	logic [4:0]        limit_q;
	logic [CNT_W-1:0]  scan_idx_q, rd_idx_s1;
	logic              rd_vld_s1;

	logic [CNT_W-1:0]  dc_cnt, ac_cnt, cnt_w;
	logic              code_phase, match, is_last;

	logic        res_v, rlast, do_emit, do_fail, do_end, do_start;
	logic [1:0]  kind;
	logic [5:0]  rpos, e_pos, end_pos;
	logic [15:0] rcoef, e_val, va_next;
	logic [3:0]  ebs1;
	logic        nf;
	logic [16:0] v_neg;
	logic [6:0]  sum_f0, target;

	always_ff @(posedge clk) begin
		if (cmd.load && table_select == SEL_DC && entry_index < 8'(DC_DEPTH)) begin
			dc_mem[entry_index[DC_AW-1:0]] <= '{entry_code_length, entry_code, entry_symbol};
		end
		dc_rd_s1 <= dc_mem[scan_idx_q[DC_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && table_select == SEL_AC) begin
			ac_mem[entry_index[AC_AW-1:0]] <= '{entry_code_length, entry_code, entry_symbol};
		end
		ac_rd_s1 <= ac_mem[scan_idx_q[AC_AW-1:0]];
	end

	assign code_phase = (phase_q == PH_DC_CODE) || (phase_q == PH_AC_CODE);
	assign dc_cnt = (dc_count_q > 5'(DC_DEPTH)) ? CNT_W'(DC_DEPTH) : CNT_W'(dc_count_q);
	assign ac_cnt = (ac_count_q > 9'(AC_DEPTH)) ? CNT_W'(AC_DEPTH) : ac_count_q;
	assign cnt_w  = (phase_q == PH_DC_CODE) ? dc_cnt : ac_cnt;
	assign ent    = (phase_q == PH_DC_CODE) ? dc_rd_s1 : ac_rd_s1;
	assign match   = rd_vld_s1 && ent.len == bits_q && ent.code == acc_q;
	assign is_last = rd_vld_s1 && rd_idx_s1 == cnt_w - CNT_W'(1);

	assign status.need_scan = code_phase && cnt_w != '0;
	assign status.scan_done = match || is_last;
	assign status.res_v     = res_v;

	// Next decoding state once the table search for this bit has finished.
	always_comb begin
		n_phase = phase_q; n_bpos = bpos_q; n_acc = acc_q; n_bits = bits_q;
		n_va = va_q; n_elen = elen_q; n_ebs = ebs_q; n_neg = neg_q;
		res_v = 1'b0; kind = KIND_COEF; rpos = '0; rcoef = '0; rlast = 1'b0;
		do_emit = 1'b0; do_fail = 1'b0; do_end = 1'b0; do_start = 1'b0;
		e_pos = '0; e_val = '0; end_pos = '0;
		va_next = {va_q[14:0], bit_q};
		ebs1    = ebs_q + 4'd1;
		nf      = (ebs_q == 4'd0) ? ~bit_q : neg_q;
		v_neg   = {1'b0, va_next} - (17'd1 << elen_q) + 17'd1;
		sum_f0  = bpos_q + 7'd16;
		target  = bpos_q + {3'b000, sym_q[7:4]};
		case (phase_q)
			PH_DC_EXTRA, PH_AC_EXTRA: begin
				n_va = va_next; n_ebs = ebs1; n_neg = nf;
				if (ebs1 >= elen_q) begin
					do_emit = 1'b1;
					e_pos = bpos_q[5:0];
					e_val = nf ? v_neg[15:0] : va_next;
				end
			end
			default: begin
				if (!hit_q) begin
					if (bits_q >= limit_q) do_fail = 1'b1;
				end else begin
					n_acc = '0; n_bits = '0;
					if (phase_q == PH_DC_CODE) begin
						if (sym_q > 8'd15) begin
							do_fail = 1'b1;
						end else if (sym_q == 8'd0) begin
							do_emit = 1'b1;
						end else begin
							n_bpos = '0; n_elen = sym_q[3:0]; n_ebs = '0;
							n_va = '0; n_neg = 1'b0; n_phase = PH_DC_EXTRA;
						end
					end else if (sym_q == 8'h00) begin
						do_end = 1'b1; end_pos = bpos_q[5:0];
					end else if (sym_q == 8'hF0) begin
						if (sum_f0 > 7'd64) begin
							do_fail = 1'b1;
						end else if (sum_f0 == 7'd64) begin
							do_end = 1'b1; end_pos = 6'd63;
						end else begin
							n_bpos = sum_f0;
						end
					end else if (target > 7'd63) begin
						do_fail = 1'b1;
					end else if (sym_q[3:0] == 4'd0) begin
						do_emit = 1'b1; e_pos = target[5:0];
					end else begin
						n_bpos = target; n_elen = sym_q[3:0]; n_ebs = '0;
						n_va = '0; n_neg = 1'b0; n_phase = PH_AC_EXTRA;
					end
				end
			end
		endcase
		if (do_emit) begin
			res_v = 1'b1; kind = KIND_COEF; rpos = e_pos; rcoef = e_val;
			if (e_pos == 6'd63) begin
				rlast = 1'b1; do_start = 1'b1;
			end else begin
				n_bpos = {1'b0, e_pos} + 7'd1; n_phase = PH_AC_CODE;
				n_acc = '0; n_bits = '0;
			end
		end
		if (do_end) begin
			res_v = 1'b1; kind = KIND_END; rpos = end_pos; rlast = 1'b1; do_start = 1'b1;
		end
		if (do_fail) begin
			res_v = 1'b1; kind = KIND_ERR; rlast = 1'b1; do_start = 1'b1;
		end
		if (do_start) begin
			n_phase = PH_DC_CODE; n_bpos = '0; n_acc = '0; n_bits = '0;
			n_va = '0; n_elen = '0; n_ebs = '0; n_neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_count_q <= '0; ac_count_q <= '0;
			phase_q <= PH_DC_CODE; bpos_q <= '0; acc_q <= '0; bits_q <= '0;
			va_q <= '0; elen_q <= '0; ebs_q <= '0; neg_q <= 1'b0;
			bit_q <= 1'b0; hit_q <= 1'b0; sym_q <= '0; limit_q <= '0;
			scan_idx_q <= '0; rd_idx_s1 <= '0; rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DC_COUNT) dc_count_q <= cfg_data[4:0];
				else ac_count_q <= cfg_data;
			end
			rd_vld_s1 <= cmd.scan && scan_idx_q < cnt_w;
			rd_idx_s1 <= scan_idx_q;
			if (cmd.take) begin
				bit_q <= stream_bit; hit_q <= 1'b0; limit_q <= '0; scan_idx_q <= '0;
				if (code_phase) begin
					if (bits_q < 5'd16) acc_q <= acc_q | (16'(stream_bit) << bits_q[3:0]);
					bits_q <= bits_q + 5'd1;
				end
			end
			if (cmd.scan) begin
				if (scan_idx_q < cnt_w) scan_idx_q <= scan_idx_q + CNT_W'(1);
				if (match) begin
					hit_q <= 1'b1; sym_q <= ent.sym;
				end
				if (is_last) limit_q <= (ent.len > 5'(MAX_LEN)) ? 5'(MAX_LEN) : ent.len;
			end
			if (cmd.commit) begin
				phase_q <= n_phase; bpos_q <= n_bpos; acc_q <= n_acc; bits_q <= n_bits;
				va_q <= n_va; elen_q <= n_elen; ebs_q <= n_ebs; neg_q <= n_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && res_v) begin
			result_kind <= kind; position <= rpos; coefficient <= rcoef;
			last_of_block <= rlast;
		end
	end

endmodule

// ===== hdl/jhbd_controller.sv =====
module jhbd_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  jhbd_pkg::dp_status_t status,
	output jhbd_pkg::dp_cmd_t    cmd
);
	import jhbd_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        out_valid_q, out_free, accept;

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && state_q == ST_IDLE;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_BIT) begin
					state_n = status.need_scan ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) state_n = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!status.res_v || out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept && operation == OP_LOAD;
				cmd.take = accept && operation == OP_BIT;
			end
			ST_SCAN: cmd.scan = 1'b1;
			ST_COMMIT: cmd.commit = !status.res_v || out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit && status.res_v) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/jpeg_huffman_block_decoder.sv =====
// Flow: a table load is written as it is accepted; a stream bit goes from ST_IDLE to
// ST_COMMIT, through ST_SCAN when it is a code bit and the table in use has entries,
// scanned one entry a cycle through the table memory port up to a match or the last.
// Throughput: one request at a time; a result waits in an output register.
// Reset: arst_n clears the control state and the count registers, the tables stay unwritten.
module jpeg_huffman_block_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic               stream_bit,
	input  logic               table_select,
	input  logic [7:0]         entry_index,
	input  logic [4:0]         entry_code_length,
	input  logic [15:0]        entry_code,
	input  logic [7:0]         entry_symbol,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic [5:0]         position,
	output logic signed [15:0] coefficient,
	output logic               last_of_block,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data
);
	import jhbd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	jhbd_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	jhbd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.stream_bit(stream_bit), .table_select(table_select),
		.entry_index(entry_index), .entry_code_length(entry_code_length),
		.entry_code(entry_code), .entry_symbol(entry_symbol),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_kind(result_kind), .position(position),
		.coefficient(coefficient), .last_of_block(last_of_block)
	);

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERR |-> position == 6'd0 && coefficient == 16'sd0
			&& last_of_block)
		else $error("error result with nonzero fields");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_END |-> last_of_block && coefficient == 16'sd0)
		else $error("block end without last flag");

	a_bit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_BIT |=> !in_ready)
		else $error("stream bit request did not occupy the decoder");

endmodule

// ===== tb/sv/jpeg_huffman_block_decoder_test.sv =====
module jpeg_huffman_block_decoder_test;
	import jhbd_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  pos;
		logic [15:0] coef;
		logic        last;
	} decoded_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic               stream_bit;
	logic               table_select;
	logic [7:0]         entry_index;
	logic [4:0]         entry_code_length;
	logic [15:0]        entry_code;
	logic [7:0]         entry_symbol;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         result_kind;
	logic [5:0]         position;
	logic signed [15:0] coefficient;
	logic               last_of_block;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [8:0]         cfg_data;

	jpeg_huffman_block_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .stream_bit(stream_bit), .table_select(table_select),
		.entry_index(entry_index), .entry_code_length(entry_code_length),
		.entry_code(entry_code), .entry_symbol(entry_symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .position(position),
		.coefficient(coefficient), .last_of_block(last_of_block),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the decoder: tables, counts and block decoding state.
	entry_t      dc_tab [DC_DEPTH];
	entry_t      ac_tab [AC_DEPTH];
	int unsigned dc_count;
	int unsigned ac_count;
	phase_t      phase;
	int unsigned blk_pos;
	int unsigned code_bits;
	int unsigned extra_len;
	int unsigned extra_seen;
	logic [15:0] code_acc;
	logic [15:0] value_acc;
	logic        neg;

	decoded_t    expected_q [$];
	logic        pending_bits [$];
	int          failures;
	bit          quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void restart_block();
		phase = PH_DC_CODE;
		blk_pos = 0;
		code_acc = '0;
		code_bits = 0;
		value_acc = '0;
		extra_len = 0;
		extra_seen = 0;
		neg = 1'b0;
	endfunction

	function automatic void push_result(logic [1:0] kind, int unsigned pos, int v, logic last);
		decoded_t r;
		r.kind = kind;
		r.pos = pos[5:0];
		r.coef = v[15:0];
		r.last = last;
		expected_q.push_back(r);
	endfunction

	function automatic void decode_error();
		restart_block();
		push_result(KIND_ERR, 0, 0, 1'b1);
	endfunction

	function automatic void finish_coef(int unsigned pos, int v);
		if (pos + 1 >= 64) begin
			restart_block();
			push_result(KIND_COEF, pos, v, 1'b1);
		end else begin
			blk_pos = pos + 1;
			phase = PH_AC_CODE;
			code_acc = '0;
			code_bits = 0;
			push_result(KIND_COEF, pos, v, 1'b0);
		end
	endfunction

	function automatic void begin_extra(int unsigned len, phase_t next);
		extra_len = len & 15;
		extra_seen = 0;
		value_acc = '0;
		neg = 1'b0;
		phase = next;
		code_acc = '0;
		code_bits = 0;
	endfunction

	function automatic entry_t table_entry(logic dc, int unsigned i);
		return dc ? dc_tab[i] : ac_tab[i];
	endfunction

	function automatic int unsigned live_count(logic dc);
		if (dc)
			return (dc_count > DC_DEPTH) ? DC_DEPTH : dc_count;
		return (ac_count > AC_DEPTH) ? AC_DEPTH : ac_count;
	endfunction

	function automatic void decode_bit(logic b);
		logic        dc;
		int unsigned cnt;
		int unsigned lim;
		logic        hit;
		logic [7:0]  sym;
		entry_t      e;
		int unsigned tgt;
		int          v;
		if (phase == PH_DC_EXTRA || phase == PH_AC_EXTRA) begin
			if (extra_seen == 0)
				neg = ~b;
			value_acc = {value_acc[14:0], b};
			extra_seen = (extra_seen + 1) & 15;
			if (extra_seen < extra_len)
				return;
			v = int'(value_acc);
			if (neg)
				v = v - (1 << extra_len) + 1;
			finish_coef(blk_pos & 63, v);
			return;
		end
		dc = (phase == PH_DC_CODE);
		cnt = live_count(dc);
		lim = 0;
		if (cnt > 0) begin
			e = table_entry(dc, cnt - 1);
			lim = (e.len > MAX_LEN) ? MAX_LEN : e.len;
		end
		if (code_bits < 16)
			code_acc[code_bits] = code_acc[code_bits] | b;
		code_bits = (code_bits + 1) & 31;
		hit = 1'b0;
		sym = '0;
		for (int i = 0; i < cnt; i++) begin
			e = table_entry(dc, i);
			if (!hit && e.len == code_bits && e.code == code_acc) begin
				sym = e.sym;
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (code_bits >= lim)
				decode_error();
			return;
		end
		code_acc = '0;
		code_bits = 0;
		if (dc) begin
			if (sym > 15)
				decode_error();
			else if (sym == 0)
				finish_coef(0, 0);
			else begin
				blk_pos = 0;
				begin_extra(sym, PH_DC_EXTRA);
			end
		end else if (sym == 8'h00) begin
			tgt = blk_pos;
			restart_block();
			push_result(KIND_END, tgt, 0, 1'b1);
		end else if (sym == 8'hF0) begin
			tgt = blk_pos + 16;
			if (tgt > 64)
				decode_error();
			else if (tgt == 64) begin
				restart_block();
				push_result(KIND_END, 63, 0, 1'b1);
			end else
				blk_pos = tgt;
		end else begin
			tgt = blk_pos + sym[7:4];
			if (tgt > 63)
				decode_error();
			else if (sym[3:0] == 0)
				finish_coef(tgt, 0);
			else begin
				blk_pos = tgt;
				begin_extra(sym[3:0], PH_AC_EXTRA);
			end
		end
	endfunction

	task automatic note_failure(string what, decoded_t want);
		failures++;
		if (failures <= 10)
			$display("mismatch (%s): kind/pos/coef/last expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
				what, want.kind, want.pos, $signed(want.coef), want.last,
				result_kind, position, coefficient, last_of_block);
	endtask

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				want = '{default: '0};
				note_failure("no result expected", want);
			end else begin
				want = expected_q.pop_front();
				if (result_kind !== want.kind || position !== want.pos ||
						coefficient !== want.coef || last_of_block !== want.last)
					note_failure("field", want);
			end
		end
	end

	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 6) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic op, logic b, logic sel, logic [7:0] idx, logic [4:0] len,
			logic [15:0] code, logic [7:0] sym);
		entry_t e;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		operation <= op;
		stream_bit <= b;
		table_select <= sel;
		entry_index <= idx;
		entry_code_length <= len;
		entry_code <= code;
		entry_symbol <= sym;
		in_valid <= 1'b1;
		if (op == OP_LOAD) begin
			e.len = len;
			e.code = code;
			e.sym = sym;
			if (sel == SEL_AC)
				ac_tab[idx] = e;
			else if (idx < DC_DEPTH)
				dc_tab[idx] = e;
		end else
			decode_bit(b);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_bit(logic b);
		send_item(OP_BIT, b, 1'($urandom), 8'($urandom), 5'($urandom), 16'($urandom),
			8'($urandom));
	endtask

	task automatic load_entry(logic sel, int unsigned idx, entry_t e);
		send_item(OP_LOAD, 1'($urandom), sel, idx[7:0], e.len, e.code, e.sym);
	endtask

	function automatic logic [7:0] pick_symbol(logic sel);
		int unsigned r;
		if (sel == SEL_DC) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				return 8'($urandom_range(16, 255));
			return 8'($urandom_range(0, (r == 1) ? 15 : 11));
		end
		r = $urandom_range(0, 15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hF0;
		if (r == 2)
			return {4'($urandom_range(4, 15)), 4'($urandom)};
		return {4'($urandom_range(0, 3)), 4'($urandom_range(0, (r == 3) ? 15 : 6))};
	endfunction

	// Canonical prefix code with the code lengths rising at random; bits are stored
	// reversed since the first received bit sits at bit 0.
	task automatic build_table(logic sel, int n, output int built);
		int unsigned len;
		int unsigned code;
		int unsigned free_slots;
		entry_t      e;
		len = (sel == SEL_DC) ? $urandom_range(1, 3) : $urandom_range(2, 5);
		code = 0;
		built = 0;
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				code++;
				free_slots = (1 << len) - code;
				if (free_slots == 0)
					break;
				if (len < MAX_LEN &&
						((free_slots <= 1 && i < n - 1) || $urandom_range(0, 2) == 0)) begin
					code = code << 1;
					len++;
				end
			end
			e.len = len[4:0];
			e.code = '0;
			for (int j = 0; j < len; j++)
				e.code[j] = code[len - 1 - j];
			e.sym = pick_symbol(sel);
			load_entry(sel, i, e);
			built++;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_index <= idx;
		cfg_data <= val[8:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DC_COUNT)
			dc_count = val & 31;
		else
			ac_count = val & 511;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned dc, int unsigned ac);
		settle();
		write_reg(REG_DC_COUNT, dc);
		write_reg(REG_AC_COUNT, ac);
		pending_bits.delete();
	endtask

	// Most bits spell whole codes of the table in use, so that blocks get deep.
	task automatic stream_bits(int n);
		logic        dc;
		int unsigned cnt;
		entry_t      e;
		for (int k = 0; k < n; k++) begin
			if (pending_bits.size() == 0) begin
				if (phase == PH_DC_EXTRA || phase == PH_AC_EXTRA)
					pending_bits.push_back(1'($urandom));
				else begin
					dc = (phase == PH_DC_CODE);
					cnt = live_count(dc);
					if (cnt == 0 || $urandom_range(0, 19) == 0)
						pending_bits.push_back(1'($urandom));
					else begin
						e = table_entry(dc, $urandom_range(0, cnt - 1));
						for (int j = 0; j < e.len; j++)
							pending_bits.push_back(e.code[j]);
					end
				end
			end
			send_bit(pending_bits.pop_front());
		end
	endtask

	task automatic send_code(entry_t e);
		for (int j = 0; j < e.len; j++)
			send_bit(e.code[j]);
	endtask

	task automatic test_directed();
		entry_t d0, d1, d2, a0, a3;
		d0 = '{len: 5'd2, code: 16'h0000, sym: 8'd0};
		d1 = '{len: 5'd2, code: 16'h0001, sym: 8'd15};
		d2 = '{len: 5'd2, code: 16'h0002, sym: 8'd16};
		a0 = '{len: 5'd1, code: 16'h0000, sym: 8'h00};
		a3 = '{len: 5'd16, code: 16'hFFFF, sym: 8'h30};
		load_entry(SEL_DC, 0, d0);
		load_entry(SEL_DC, 1, d1);
		load_entry(SEL_DC, 2, d2);
		// Out-of-range DC index: must be ignored.
		send_item(OP_LOAD, 1'b1, SEL_DC, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF);
		load_entry(SEL_AC, 0, a0);
		load_entry(SEL_AC, 1, '{len: 5'd2, code: 16'h0001, sym: 8'hF0});
		load_entry(SEL_AC, 2, '{len: 5'd3, code: 16'h0003, sym: 8'h0F});
		load_entry(SEL_AC, 3, a3);
		configure(3, 4);
		send_code(d0);
		send_code(a3);
		send_code(a0);
		send_code(d2);
		send_bit(1'b1);
		send_bit(1'b1);
	endtask

	task automatic test_empty_tables();
		configure(0, 0);
		stream_bits(15);
		configure(3, 0);
		stream_bits(15);
	endtask

	task automatic test_full_tables();
		int dc_n, ac_n;
		build_table(SEL_DC, DC_DEPTH, dc_n);
		build_table(SEL_AC, AC_DEPTH, ac_n);
		configure(dc_n, ac_n);
		stream_bits(150);
	endtask

	task automatic test_varied_tables();
		int dc_n, ac_n;
		repeat (3) begin
			build_table(SEL_DC, $urandom_range(1, 8), dc_n);
			build_table(SEL_AC, $urandom_range(2, 40), ac_n);
			configure(dc_n, ac_n);
			stream_bits(60);
		end
	endtask

	task automatic test_single_entry();
		int dc_n, ac_n;
		build_table(SEL_DC, 1, dc_n);
		build_table(SEL_AC, 1, ac_n);
		configure(dc_n, ac_n);
		stream_bits(40);
	endtask

	task automatic test_back_to_back();
		int dc_n, ac_n;
		quiet = 1'b1;
		build_table(SEL_DC, 10, dc_n);
		build_table(SEL_AC, 60, ac_n);
		configure(dc_n, ac_n);
		stream_bits(150);
	endtask

	initial begin
		failures = 0;
		quiet = 1'b0;
		dc_count = 0;
		ac_count = 0;
		restart_block();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_BIT;
		stream_bit <= 1'b0;
		table_select <= SEL_DC;
		entry_index <= '0;
		entry_code_length <= '0;
		entry_code <= '0;
		entry_symbol <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DC_COUNT;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_empty_tables();
		test_full_tables();
		test_varied_tables();
		test_single_entry();
		test_back_to_back();
		settle();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#12000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/jhbd_pkg.sv
hdl/jhbd_datapath.sv
hdl/jhbd_controller.sv
hdl/jpeg_huffman_block_decoder.sv
tb/sv/jpeg_huffman_block_decoder_test.sv
